### src/skewed_predicate_predictor_assert.svh
// Assertion macros used by the predictor's controller (spp_ctrl).
`ifndef SKEWED_PREDICATE_PREDICTOR_ASSERT_SVH
`define SKEWED_PREDICATE_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spp assertion failed");

// Next-cycle implication, checked out of reset.
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spp assertion failed");

`endif

### src/spp_pkg.sv
// Package: sizes, codes, types and hash helpers of the skewed predicate predictor.
package spp_pkg;

    localparam int INDEX_BITS = 12;
    localparam int HIST_BITS  = 16;

    localparam logic [1:0] MODE_QUERY   = 2'd0;
    localparam logic [1:0] MODE_PREDICT = 2'd1;
    localparam logic [1:0] MODE_TRAIN   = 2'd2;
    localparam logic [1:0] MODE_RESTORE = 2'd3;

    // 2-bit counter: 0 strong false, 1 weak false, 2 weak true, 3 strong true
    localparam logic [1:0] CTR_STRONG_FALSE = 2'd0;
    localparam logic [1:0] CTR_WEAK_FALSE   = 2'd1;
    localparam logic [1:0] CTR_STRONG_TRUE  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] instr_addr;
        logic [1:0]  slot_offset;
        logic [5:0]  pred_reg;
        logic        outcome;
        logic [15:0] hist_value;
    } t_req;

    typedef struct packed {
        logic                  load;
        logic                  read;
        logic                  update;
        logic                  emit;
        logic                  clr_we;
        logic [INDEX_BITS-1:0] clr_addr;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // H rotation (bit 62 of the result is zero, not v[63])
    function automatic logic [63:0] rot_h(input logic [63:0] v);
        return {v[63] ^ v[0], 1'b0, v[62:1]};
    endfunction

    // inverse-H rotation
    function automatic logic [63:0] rot_hi(input logic [63:0] v);
        return {v[62:0], v[63] ^ v[62]};
    endfunction

    function automatic logic ctr_strong(input logic [1:0] c);
        return (c == CTR_STRONG_FALSE) || (c == CTR_STRONG_TRUE);
    endfunction

    function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic up);
        logic [1:0] res;
        res = c;
        if (up) begin
            if (c != CTR_STRONG_TRUE) res = c + 2'd1;
        end else begin
            if (c != CTR_STRONG_FALSE) res = c - 2'd1;
        end
        return res;
    endfunction

    function automatic logic vote3(input logic a, input logic b, input logic c);
        return (a & b) | (a & c) | (b & c);
    endfunction

endpackage

### src/spp_if.sv
// Request and response channel interfaces of the predictor.
interface spp_req_if import spp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] instr_addr;
    logic [1:0]  slot_offset;
    logic [5:0]  pred_reg;
    logic        outcome;
    logic [15:0] hist_value;

    modport source (output valid, mode, instr_addr, slot_offset, pred_reg, outcome,
                    hist_value, input ready);
    modport sink (input valid, mode, instr_addr, slot_offset, pred_reg, outcome,
                  hist_value, output ready);
endinterface

interface spp_rsp_if import spp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        prediction;
    logic        confident;
    logic [15:0] history_out;

    modport source (output valid, prediction, confident, history_out, input ready);
    modport sink (input valid, prediction, confident, history_out, output ready);
endinterface

### src/spp_ctrl.sv
// Controller: bank clearing pass and per-transaction sequencing.
`include "skewed_predicate_predictor_assert.svh"

module spp_ctrl import spp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr, n_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.clr_addr = r_clr;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr        = r_clr + 1'b1;
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    `SPP_ASSERT_NEXT(a_load_reads, i_clk, i_rst_n, o_cmd.load, o_cmd.read)
    `SPP_ASSERT_NEXT(a_read_updates, i_clk, i_rst_n, o_cmd.read, o_cmd.update)
    `SPP_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, o_cmd.emit, o_in_ready && !o_cmd.emit)
    `SPP_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, o_cmd.clr_we,
                    !o_in_ready && !o_cmd.update)

endmodule

### src/spp_dp.sv
// Datapath: item registers, history, counter banks, vote logic and output register.
module spp_dp import spp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    input  t_req           i_req,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    output t_sts           o_sts,
    spp_rsp_if.source      o_rsp
);

    logic                  r_use_conf;
    logic [HIST_BITS-1:0]  r_ghist, n_ghist;
    logic [1:0]            r_mode;
    logic [63:0]           r_addr;
    logic [5:0]            r_preg;
    logic                  r_outc;
    logic [HIST_BITS-1:0]  r_hval;
    logic [INDEX_BITS-1:0] r_idx0, r_idx1, r_idx2;
    logic [INDEX_BITS-1:0] n_idx0, n_idx1, n_idx2;
    logic [1:0]            r_rd0, r_rd1, r_rd2;
    logic                  r_pred, r_conf, n_pred, n_conf;
    logic                  r_out_valid;

    logic [1:0] r_bank0 [2**INDEX_BITS];
    logic [1:0] r_bank1 [2**INDEX_BITS];
    logic [1:0] r_bank2 [2**INDEX_BITS];

    logic [63:0]           w_h;
    logic                  w_train;
    logic                  w_we;
    logic [INDEX_BITS-1:0] w_wa0, w_wa1, w_wa2;
    logic [1:0]            w_wd0, w_wd1, w_wd2;
    logic                  w_dir, w_strong;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_conf <= 1'b0;
        end else if (i_cfg_we) begin
            r_use_conf <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_req.mode;
            r_addr <= i_req.instr_addr + 64'(i_req.slot_offset);
            r_preg <= i_req.pred_reg;
            r_outc <= i_req.outcome;
            r_hval <= HIST_BITS'(i_req.hist_value);
        end
    end

    // train hashes with the recorded history, all other modes with the live one
    always_comb begin
        w_h    = (r_mode == MODE_TRAIN) ? 64'(r_hval) : 64'(r_ghist);
        n_idx0 = INDEX_BITS'(rot_h(r_addr) ^ rot_hi(w_h) ^ w_h);
        n_idx1 = INDEX_BITS'(rot_h(r_addr) ^ rot_hi(w_h) ^ r_addr);
        n_idx2 = INDEX_BITS'(rot_hi(r_addr) ^ rot_h(w_h) ^ w_h);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_idx0 <= n_idx0;
            r_idx1 <= n_idx1;
            r_idx2 <= n_idx2;
            r_rd0  <= r_bank0[n_idx0];
            r_rd1  <= r_bank1[n_idx1];
            r_rd2  <= r_bank2[n_idx2];
        end
    end

    assign w_train = i_cmd.update && (r_mode == MODE_TRAIN) && (r_preg != 6'd0);
    assign w_we    = i_cmd.clr_we || w_train;
    assign w_wa0   = i_cmd.clr_we ? i_cmd.clr_addr : r_idx0;
    assign w_wa1   = i_cmd.clr_we ? i_cmd.clr_addr : r_idx1;
    assign w_wa2   = i_cmd.clr_we ? i_cmd.clr_addr : r_idx2;
    assign w_wd0   = i_cmd.clr_we ? CTR_WEAK_FALSE : ctr_train(r_rd0, r_outc);
    assign w_wd1   = i_cmd.clr_we ? CTR_WEAK_FALSE : ctr_train(r_rd1, r_outc);
    assign w_wd2   = i_cmd.clr_we ? CTR_WEAK_FALSE : ctr_train(r_rd2, r_outc);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_bank0[w_wa0] <= w_wd0;
            r_bank1[w_wa1] <= w_wd1;
            r_bank2[w_wa2] <= w_wd2;
        end
    end

    assign w_dir    = vote3(r_rd0[1], r_rd1[1], r_rd2[1]);
    assign w_strong = vote3(ctr_strong(r_rd0), ctr_strong(r_rd1), ctr_strong(r_rd2));

    always_comb begin
        n_ghist = r_ghist;
        n_pred  = 1'b0;
        n_conf  = 1'b0;
        case (r_mode)
            MODE_QUERY: begin
                n_conf = r_use_conf ? w_strong : 1'b1;
            end
            MODE_PREDICT: begin
                if (r_preg == 6'd0) begin
                    n_pred = 1'b1;
                end else begin
                    n_pred  = w_dir;
                    n_ghist = {r_ghist[HIST_BITS-2:0], w_dir};
                end
            end
            MODE_RESTORE: begin
                n_ghist = r_hval;
            end
            default: begin
                n_ghist = r_ghist;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist <= '0;
        end else if (i_cmd.update) begin
            r_ghist <= n_ghist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_pred <= n_pred;
            r_conf <= n_conf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_rsp.prediction  <= r_pred;
            o_rsp.confident   <= r_conf;
            o_rsp.history_out <= 16'(r_ghist);
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || o_rsp.ready;

endmodule

### src/skewed_predicate_predictor.sv
// Top level of the three-bank skewed predicate predictor.
//
// Usage:
//   i_req carries one transaction per request: mode (query, predict, train,
//   restore), bundle address, slot, predicate register, outcome and history.
//   o_rsp returns exactly one transaction per request: prediction, confident
//   flag and the global history after that request, in request order.
//   i_cfg_we / i_cfg_wdata write use_confidence; write it only while idle.
// Sequencing:
//   Each transaction steps through accept, counter bank read, counter update
//   and vote, and output load; a new request is accepted only after the output
//   load. The pace is set by the read-then-write of the three single-write-port
//   counter banks. Response valid comes from the output register, set at output load.
// Reset:
//   i_rst_n is synchronous, active low. History and use_confidence clear,
//   then a clearing pass writes all 4096 entries of each bank to weakly
//   false, one entry per cycle; i_req.ready stays low until the pass ends.
// Backpressure:
//   A held response sits in the output register; one more request is taken
//   and worked, then the block waits with i_req.ready low until o_rsp drains.
module skewed_predicate_predictor import spp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spp_req_if.sink    i_req,
    spp_rsp_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_req w_req;
    logic w_in_ready;

    // pack the request payload for the datapath
    assign w_req.mode        = i_req.mode;
    assign w_req.instr_addr  = i_req.instr_addr;
    assign w_req.slot_offset = i_req.slot_offset;
    assign w_req.pred_reg    = i_req.pred_reg;
    assign w_req.outcome     = i_req.outcome;
    assign w_req.hist_value  = i_req.hist_value;

    assign i_req.ready = w_in_ready;

    spp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    spp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (w_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (w_sts),
        .o_rsp       (o_rsp)
    );

endmodule
